// ===== hw/rtl/ihl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihl_pkg
// Shared types, codes and helpers for the hex record loader.
// ----------------------------------------------------------------------------
package ihl_pkg;

    // Default width of the load address
    localparam int ADDR_BITS_DEFAULT = 16;

    // Record start character
    localparam logic [7:0] START_CHAR = 8'h3A;
    // Character that marks an unexpected end of the stream
    localparam logic [7:0] END_MARK   = 8'hFF;

    // Status codes
    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_EOF      = 3'd2;
    localparam logic [2:0] ST_UNEXP    = 3'd3;
    localparam logic [2:0] ST_BADSTART = 3'd4;
    localparam logic [2:0] ST_BADTYPE  = 3'd5;
    localparam logic [2:0] ST_CSUM     = 3'd6;

    // Record types
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;

    // One result item
    typedef struct packed {
        logic        write_valid;
        logic [15:0] write_addr;
        logic [7:0]  write_data;
        logic [2:0]  status;
    } ihl_result_t;

    // Convert one hex character; characters above '9' lose 55, all else loses 48, 8-bit wrap
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        if (c > 8'h39) begin
            v = c - 8'd55;
        end else begin
            v = c - 8'd48;
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/ihl_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihl_parser
// Record state machine: holds the parse state and works out the result of
// the current character in one pass.
// ----------------------------------------------------------------------------
module ihl_parser #(
    parameter int ADDR_BITS = ihl_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic [7:0]          char_in,
    output ihl_pkg::ihl_result_t result
);

    // Phase codes
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_AHI   = 3'd2;
    localparam logic [2:0] PH_ALO   = 3'd3;
    localparam logic [2:0] PH_TYPE  = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_CSUM  = 3'd6;
    localparam logic [2:0] PH_EOL   = 3'd7;

    logic [2:0]           phase_reg, phase_next;
    logic                 hnp_reg, hnp_next;
    logic [7:0]           acc_reg, acc_next;
    logic [7:0]           left_reg, left_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [7:0]           sum_reg, sum_next;
    logic [2:0]           fin_reg, fin_next;

    logic [7:0]  digit;
    logic [7:0]  byte_val;
    logic [7:0]  left_dec;
    logic [31:0] addr_ext;

    assign digit    = ihl_pkg::digit_value(char_in);
    assign byte_val = acc_reg + digit;
    assign left_dec = left_reg - 8'd1;
    assign addr_ext = 32'(addr_reg);

    // Work out next state and the result of this character
    always_comb begin
        phase_next = phase_reg;
        hnp_next   = hnp_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        addr_next  = addr_reg;
        sum_next   = sum_reg;
        fin_next   = fin_reg;
        result     = '0;

        if (fin_reg != ihl_pkg::ST_BUSY) begin
            // Hold the final status
            result.status = fin_reg;
        end else if (phase_reg == PH_START) begin
            if (char_in == ihl_pkg::END_MARK) begin
                fin_next = ihl_pkg::ST_UNEXP;
            end else if (char_in != ihl_pkg::START_CHAR) begin
                fin_next = ihl_pkg::ST_BADSTART;
            end else begin
                sum_next   = 8'd0;
                hnp_next   = 1'b0;
                phase_next = PH_COUNT;
            end
            result.status = fin_next;
        end else if (phase_reg == PH_EOL) begin
            // Line end: test the checksum
            if (sum_reg == 8'd0) begin
                result.status = ihl_pkg::ST_OK;
                phase_next    = PH_START;
            end else begin
                fin_next      = ihl_pkg::ST_CSUM;
                result.status = ihl_pkg::ST_CSUM;
            end
        end else if (!hnp_reg) begin
            // First digit of a byte
            acc_next = {digit[3:0], 4'b0000};
            hnp_next = 1'b1;
        end else begin
            // Second digit completes a byte
            hnp_next = 1'b0;
            sum_next = sum_reg + byte_val;
            unique case (phase_reg)
                PH_COUNT: begin
                    left_next = byte_val;
                    if (byte_val == 8'd0) begin
                        fin_next = ihl_pkg::ST_EOF;
                    end else begin
                        phase_next = PH_AHI;
                    end
                end
                PH_AHI: begin
                    addr_next  = ADDR_BITS'(32'(byte_val));
                    phase_next = PH_ALO;
                end
                PH_ALO: begin
                    addr_next  = ADDR_BITS'({16'd0, addr_ext[7:0], byte_val});
                    phase_next = PH_TYPE;
                end
                PH_TYPE: begin
                    if (byte_val == ihl_pkg::REC_EOF) begin
                        fin_next = ihl_pkg::ST_EOF;
                    end else if (byte_val != ihl_pkg::REC_DATA) begin
                        fin_next = ihl_pkg::ST_BADTYPE;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    result.write_valid = 1'b1;
                    result.write_addr  = addr_ext[15:0];
                    result.write_data  = byte_val;
                    addr_next          = addr_reg + ADDR_BITS'(1);
                    left_next          = left_dec;
                    if (left_dec == 8'd0) begin
                        phase_next = PH_CSUM;
                    end
                end
                default: begin
                    // Checksum byte done, expect the line end
                    phase_next = PH_EOL;
                end
            endcase
            result.status = fin_next;
        end
    end

    // Advance the state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            hnp_reg   <= 1'b0;
            acc_reg   <= 8'd0;
            left_reg  <= 8'd0;
            addr_reg  <= '0;
            sum_reg   <= 8'd0;
            fin_reg   <= ihl_pkg::ST_BUSY;
        end else if (step_en) begin
            phase_reg <= phase_next;
            hnp_reg   <= hnp_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            addr_reg  <= addr_next;
            sum_reg   <= sum_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

// ===== hw/rtl/intel_hex_record_loader_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intel_hex_record_loader_core
// Parses a hex record text stream and issues memory byte writes.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one text character per item on the s_ channel (s_tdata[7:0]).
//   Every accepted character produces exactly one result item on the m_
//   channel: a write flag, address and byte, plus a status code.
//   m_tvalid rises in the cycle after input accept; one character is
//   taken every cycle while the receiver does not stall, with the single-pass
//   parser between the state flip-flops and the output register.
//   When the receiver stalls (m_tready low), the result is held in the
//   output register and s_tready drops until it is taken; it rises again in
//   the cycle the result leaves, so a new item enters alongside.
//   Reset (aresetn low, synchronous) returns the parser to waiting for a
//   start character, clears any finished or error status and empties the
//   output register. End-of-file and error statuses are sticky until reset.
// ----------------------------------------------------------------------------
module intel_hex_record_loader_core #(
    parameter int ADDR_BITS = ihl_pkg::ADDR_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] write_addr, [23:16] write_data
    output logic [3:0]  m_tuser    // [0] write_valid, [3:1] status
);

    ihl_pkg::ihl_result_t step_res;
    ihl_pkg::ihl_result_t out_reg;
    logic                 valid_reg;
    logic                 accept;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    ihl_parser #(
        .ADDR_BITS (ADDR_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (accept),
        .char_in (s_tdata),
        .result  (step_res)
    );

    // Output valid: load on accept, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= step_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {out_reg.write_data, out_reg.write_addr};
    assign m_tuser  = {out_reg.status, out_reg.write_valid};

endmodule

// ===== hw/rtl/ihl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihl_checker
// Port-level checks on the hex record loader, bound to the top level.
// ----------------------------------------------------------------------------
module ihl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [3:0]  m_tuser
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Every accepted character yields a result next cycle
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item gave no result");

    // A write only while busy; no write leaves address and data zero
    a_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[3:1] == ihl_pkg::ST_BUSY)
        else $error("write with final status");

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 24'd0)
        else $error("payload set without write");

endmodule

bind intel_hex_record_loader_core ihl_checker u_ihl_checker (.*);

// ===== test/intel_hex_record_loader_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intel_hex_record_loader_core_tb
// Self-checking bench for the hex record loader. Record text is streamed in
// one character per item, with random gaps on the input and random stalls on
// the output. A behavioural parser predicts the write and status of every
// character, and each result item is checked against it in order. The run
// covers well-formed records, odd digit characters, address wrap and a full
// 255-byte record. It then closes the file with one randomly chosen end or
// error condition, followed by characters that must keep the sticky status.
// ----------------------------------------------------------------------------
module intel_hex_record_loader_core_tb;

    localparam int RANDOM_CHARS = 1350;
    localparam int IDLE_LIMIT   = 2000;
    localparam int MAX_REPORTS  = 10;

    // Parser phases of the predictor
    typedef enum logic [2:0] {
        WAIT_COLON, GET_COUNT, GET_ADDR_HI, GET_ADDR_LO,
        GET_TYPE, GET_DATA, GET_CSUM, GET_LINE_END
    } parse_phase_t;

    // Ways to close the file at the end of the run
    typedef enum int {
        END_ZERO_COUNT, END_TYPE_ONE, END_BAD_TYPE,
        END_BAD_CSUM, END_BAD_START, END_MARKER
    } file_end_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [3:0]  m_tuser;

    // Predictor state
    parse_phase_t pr_phase     = WAIT_COLON;
    logic         pr_low_digit = 1'b0;
    logic [7:0]   pr_acc       = 8'h00;
    logic [7:0]   pr_left      = 8'h00;
    logic [15:0]  pr_addr      = 16'h0000;
    logic [7:0]   pr_sum       = 8'h00;
    logic [2:0]   pr_done      = ihl_pkg::ST_BUSY;

    ihl_pkg::ihl_result_t expected_writes_q[$];
    logic [7:0]           data_chars_q[$];

    int chars_sent     = 0;
    int burst_left     = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;
    int ready_mode     = 0;
    int ready_mode_left = 0;
    int rx_cycle       = 0;

    intel_hex_record_loader_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    // Value of one text character: characters above '9' lose 55, everything else 48
    function automatic logic [7:0] nibble_of(input logic [7:0] c);
        if (c > 8'h39) begin
            return c - 8'd55;
        end
        return c - 8'd48;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + n;
        end
        return 8'h41 + (n - 4'd10);
    endfunction

    // Advance the predicted parser by one character and return its result
    function automatic ihl_pkg::ihl_result_t predict_char(input logic [7:0] c);
        ihl_pkg::ihl_result_t r;
        logic [7:0]           b;
        r = '0;
        if (pr_done != ihl_pkg::ST_BUSY) begin
            r.status = pr_done;
        end else if (pr_phase == WAIT_COLON) begin
            if (c == ihl_pkg::END_MARK) begin
                pr_done = ihl_pkg::ST_UNEXP;
            end else if (c != ihl_pkg::START_CHAR) begin
                pr_done = ihl_pkg::ST_BADSTART;
            end else begin
                pr_sum       = 8'h00;
                pr_low_digit = 1'b0;
                pr_phase     = GET_COUNT;
            end
            r.status = pr_done;
        end else if (pr_phase == GET_LINE_END) begin
            if (pr_sum == 8'h00) begin
                r.status = ihl_pkg::ST_OK;
                pr_phase = WAIT_COLON;
            end else begin
                pr_done  = ihl_pkg::ST_CSUM;
                r.status = ihl_pkg::ST_CSUM;
            end
        end else if (!pr_low_digit) begin
            pr_acc       = nibble_of(c) << 4;
            pr_low_digit = 1'b1;
        end else begin
            b            = pr_acc + nibble_of(c);
            pr_low_digit = 1'b0;
            pr_sum       = pr_sum + b;
            case (pr_phase)
                GET_COUNT: begin
                    pr_left = b;
                    if (b == 8'h00) begin
                        pr_done = ihl_pkg::ST_EOF;
                    end else begin
                        pr_phase = GET_ADDR_HI;
                    end
                end
                GET_ADDR_HI: begin
                    pr_addr  = {8'h00, b};
                    pr_phase = GET_ADDR_LO;
                end
                GET_ADDR_LO: begin
                    pr_addr  = {pr_addr[7:0], b};
                    pr_phase = GET_TYPE;
                end
                GET_TYPE: begin
                    if (b == ihl_pkg::REC_EOF) begin
                        pr_done = ihl_pkg::ST_EOF;
                    end else if (b != ihl_pkg::REC_DATA) begin
                        pr_done = ihl_pkg::ST_BADTYPE;
                    end else begin
                        pr_phase = GET_DATA;
                    end
                end
                GET_DATA: begin
                    r.write_valid = 1'b1;
                    r.write_addr  = pr_addr;
                    r.write_data  = b;
                    pr_addr       = pr_addr + 16'd1;
                    pr_left       = pr_left - 8'd1;
                    if (pr_left == 8'h00) begin
                        pr_phase = GET_CSUM;
                    end
                end
                default: begin
                    pr_phase = GET_LINE_END;
                end
            endcase
            r.status = pr_done;
        end
        return r;
    endfunction

    // Offer one character; idle in random bursts and gaps, hold until taken
    task automatic send_char(input logic [7:0] c);
        int gap;
        int sel;
        if (burst_left == 0) begin
            sel = $urandom_range(0, 9);
            if (sel < 4) begin
                gap = 0;
            end else if (sel < 8) begin
                gap = $urandom_range(1, 3);
            end else begin
                gap = $urandom_range(4, 12);
            end
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        expected_writes_q.push_back(predict_char(c));
        chars_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_hex_byte(input logic [7:0] b);
        send_char(hex_char(b[7:4]));
        send_char(hex_char(b[3:0]));
    endtask

    // Queue data digits: plain hex, or any two characters at all
    task automatic queue_data_byte(input bit odd_digits);
        logic [7:0] b;
        if (odd_digits) begin
            data_chars_q.push_back(8'($urandom_range(0, 255)));
            data_chars_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            b = 8'($urandom_range(0, 255));
            data_chars_q.push_back(hex_char(b[7:4]));
            data_chars_q.push_back(hex_char(b[3:0]));
        end
    endtask

    // Send one record carrying the queued data digits; skew spoils the sum
    task automatic send_record(input logic [15:0] addr, input logic [7:0] rtype,
                               input logic [7:0] skew, input logic [7:0] line_end);
        logic [7:0] count;
        logic [7:0] sum;
        int         i;
        count = 8'(data_chars_q.size() / 2);
        sum   = count + addr[15:8] + addr[7:0] + rtype;
        send_char(ihl_pkg::START_CHAR);
        send_hex_byte(count);
        send_hex_byte(addr[15:8]);
        send_hex_byte(addr[7:0]);
        send_hex_byte(rtype);
        for (i = 0; i < data_chars_q.size(); i += 2) begin
            sum = sum + 8'((nibble_of(data_chars_q[i]) << 4) + nibble_of(data_chars_q[i+1]));
            send_char(data_chars_q[i]);
            send_char(data_chars_q[i+1]);
        end
        send_hex_byte(8'h00 - sum + skew);
        send_char(line_end);
        data_chars_q.delete();
    endtask

    function automatic logic [7:0] random_line_end();
        if ($urandom_range(0, 1) == 0) begin
            return 8'h0A;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Extreme bytes across the top of the address space, and odd digits
    task automatic test_directed_records();
        data_chars_q.push_back(hex_char(4'h0));
        data_chars_q.push_back(hex_char(4'h0));
        data_chars_q.push_back(hex_char(4'hF));
        data_chars_q.push_back(hex_char(4'hF));
        send_record(16'hFFFF, ihl_pkg::REC_DATA, 8'h00, 8'h0D);
        data_chars_q.push_back(8'hFF);
        data_chars_q.push_back(8'h00);
        send_record(16'h0000, ihl_pkg::REC_DATA, 8'h00, 8'hFF);
    endtask

    task automatic test_full_length_record();
        int i;
        for (i = 0; i < 255; i++) begin
            queue_data_byte($urandom_range(0, 3) == 0);
        end
        send_record(16'($urandom_range(0, 65535)), ihl_pkg::REC_DATA, 8'h00,
                    random_line_end());
    endtask

    // Well-formed records with random content; drain once midway
    task automatic test_random_records();
        int         start;
        int         n;
        int         i;
        bit         drained;
        bit         odd;
        logic [15:0] addr;
        start   = chars_sent;
        drained = 1'b0;
        while (chars_sent - start < RANDOM_CHARS) begin
            if (!drained && chars_sent - start >= RANDOM_CHARS / 2) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (expected_writes_q.size() != 0) @(posedge aclk);
                burst_left = 0;
                drained    = 1'b1;
            end
            n    = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            odd  = ($urandom_range(0, 9) < 3);
            addr = ($urandom_range(0, 3) == 0) ? 16'(16'hFFF0 + $urandom_range(0, 15))
                                               : 16'($urandom_range(0, 65535));
            for (i = 0; i < n; i++) begin
                queue_data_byte(odd);
            end
            send_record(addr, ihl_pkg::REC_DATA, 8'h00, random_line_end());
        end
    endtask

    // Close the file one way, then check the status stays put
    task automatic test_file_end();
        file_end_t  how;
        int         i;
        logic [7:0] c;
        how = file_end_t'($urandom_range(0, 5));
        case (how)
            END_ZERO_COUNT: begin
                send_record(16'h0000, ihl_pkg::REC_EOF, 8'h00, 8'h0A);
            end
            END_TYPE_ONE: begin
                queue_data_byte(1'b0);
                send_record(16'($urandom_range(0, 65535)), ihl_pkg::REC_EOF, 8'h00, 8'h0A);
            end
            END_BAD_TYPE: begin
                queue_data_byte(1'b0);
                send_record(16'($urandom_range(0, 65535)), 8'($urandom_range(2, 255)),
                            8'h00, 8'h0A);
            end
            END_BAD_CSUM: begin
                queue_data_byte(1'b1);
                queue_data_byte(1'b0);
                send_record(16'($urandom_range(0, 65535)), ihl_pkg::REC_DATA,
                            8'($urandom_range(1, 255)), 8'h0A);
            end
            END_BAD_START: begin
                do c = 8'($urandom_range(0, 255));
                while (c == ihl_pkg::START_CHAR || c == ihl_pkg::END_MARK);
                send_char(c);
            end
            default: begin
                send_char(ihl_pkg::END_MARK);
            end
        endcase
        for (i = 0; i < 8; i++) begin
            send_char((i == 0) ? ihl_pkg::START_CHAR : 8'($urandom_range(0, 255)));
        end
    endtask

    // Receiver stall pattern: switch between a few ready profiles
    always @(posedge aclk) begin
        if (ready_mode_left == 0) begin
            ready_mode      <= $urandom_range(0, 3);
            ready_mode_left <= $urandom_range(32, 256);
        end else begin
            ready_mode_left <= ready_mode_left - 1;
        end
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ((rx_cycle % 7) < 4);
            default: m_tready <= ((rx_cycle % 24) >= 16);
        endcase
        rx_cycle <= rx_cycle + 1;
    end

    // Compare each result item with the oldest prediction
    always @(posedge aclk) begin
        ihl_pkg::ihl_result_t act;
        ihl_pkg::ihl_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            act.write_valid = m_tuser[0];
            act.status      = m_tuser[3:1];
            act.write_addr  = m_tdata[15:0];
            act.write_data  = m_tdata[23:16];
            if (expected_writes_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected item: wv=%0d addr=%h data=%h status=%0d",
                             act.write_valid, act.write_addr, act.write_data, act.status);
                end
            end else begin
                exp_r = expected_writes_q.pop_front();
                if (act.write_valid != exp_r.write_valid || act.write_addr != exp_r.write_addr ||
                    act.write_data != exp_r.write_data || act.status != exp_r.status) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: exp %0d/%h/%h/%0d got %0d/%h/%h/%0d",
                                 exp_r.write_valid, exp_r.write_addr, exp_r.write_data,
                                 exp_r.status, act.write_valid, act.write_addr,
                                 act.write_data, act.status);
                    end
                end
            end
        end
    end

    // Watchdog: give up when neither side moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_records();
        test_full_length_record();
        test_random_records();
        test_file_end();
        s_tvalid <= 1'b0;
        while (expected_writes_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && expected_writes_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
